FILE: src/left_to_right_expression_evaluator_defines.svh
// assertion macros for the left-to-right expression evaluator
`ifndef LEFT_TO_RIGHT_EXPRESSION_EVALUATOR_DEFINES_SVH
`define LEFT_TO_RIGHT_EXPRESSION_EVALUATOR_DEFINES_SVH
`ifndef SYNTHESIS
// checked property, off while reset is high
`define LREV_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);
// checked property, also evaluated around reset
`define LREV_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LREV_ASSERT(label, clk, rst, prop, msg)
`define LREV_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: src/lrev_pkg.sv
// shared types, microcode encoding and character codes of the evaluator
package lrev_pkg;

  localparam int ACC_W = 48;
  localparam int CNT_W = $clog2(ACC_W);
  localparam int UPC_W = 6;
  localparam logic [ACC_W-1:0] ACC_MAX = 48'h7FFF_FFFF_FFFF;

  // ascii codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    ST_OK,
    ST_SYNTAX,
    ST_DIVZERO,
    ST_OVERFLOW
  } status_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_DIGITS,
    PH_DISCARD
  } phase_t;

  // datapath operation of one microcode step
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_FETCH,
    ACT_LOAD,
    ACT_ADDSUB,
    ACT_SET_OP,
    ACT_DIGIT,
    ACT_CLEAR,
    ACT_FINISH,
    ACT_MUL_INIT,
    ACT_MUL_STEP,
    ACT_MUL_STORE,
    ACT_DIV_INIT,
    ACT_DIV_STEP,
    ACT_DIV_STORE
  } act_t;

  // jump condition of one microcode step
  typedef enum logic [4:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_DISCARD,
    COND_SPACE,
    COND_DIGIT,
    COND_PHASE0,
    COND_NOT_OPEQ,
    COND_HAVE,
    COND_OPR_BIG,
    COND_PEND_MUL,
    COND_PEND_DIV,
    COND_SUM_OVF,
    COND_EQUAL,
    COND_DIG_OVF,
    COND_NOT_NEWLINE,
    COND_OUT_BUSY,
    COND_MORE,
    COND_MUL_OVF,
    COND_OPND_ZERO
  } cond_t;

  typedef logic [UPC_W-1:0] upc_t;

  typedef struct packed {
    act_t    act;
    cond_t   cond;
    upc_t    target;
    status_t st;
  } ucode_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic discard;
    logic newline;
    logic space;
    logic digit;
    logic phase0;
    logic not_opeq;
    logic have;
    logic opr_big;
    logic pend_mul;
    logic pend_div;
    logic sum_ovf;
    logic equal;
    logic dig_ovf;
    logic more;
    logic mul_ovf;
    logic opnd_zero;
  } flags_t;

  // microcode entry points
  localparam upc_t UA_IDLE    = 6'd0;
  localparam upc_t UA_APPLY   = 6'd9;
  localparam upc_t UA_APPLIED = 6'd14;
  localparam upc_t UA_DIG     = 6'd16;
  localparam upc_t UA_DISC    = 6'd18;
  localparam upc_t UA_MUL     = 6'd20;
  localparam upc_t UA_MUL_LP  = 6'd21;
  localparam upc_t UA_DIV     = 6'd24;
  localparam upc_t UA_DIV_LP  = 6'd26;
  localparam upc_t UA_SYN     = 6'd28;
  localparam upc_t UA_OK      = 6'd30;
  localparam upc_t UA_OVF     = 6'd32;
  localparam upc_t UA_DVZ     = 6'd34;

endpackage

FILE: src/lrev_ucode_rom.sv
// microcode program of the evaluator sequencer
module lrev_ucode_rom (
  input  lrev_pkg::upc_t   addr,
  output lrev_pkg::ucode_t word
);
  import lrev_pkg::*;

  always_comb begin
    case (addr)
      // fetch and classify the character
      6'd0:  word = '{ACT_FETCH, COND_NO_INPUT, UA_IDLE, ST_OK};
      6'd1:  word = '{ACT_NONE, COND_DISCARD, UA_DISC, ST_OK};
      6'd2:  word = '{ACT_NONE, COND_SPACE, UA_IDLE, ST_OK};
      6'd3:  word = '{ACT_NONE, COND_DIGIT, UA_DIG, ST_OK};
      6'd4:  word = '{ACT_NONE, COND_PHASE0, UA_SYN, ST_OK};
      6'd5:  word = '{ACT_NONE, COND_NOT_OPEQ, UA_SYN, ST_OK};
      // first operand goes straight into the accumulator
      6'd6:  word = '{ACT_NONE, COND_HAVE, UA_APPLY, ST_OK};
      6'd7:  word = '{ACT_NONE, COND_OPR_BIG, UA_OVF, ST_OK};
      6'd8:  word = '{ACT_LOAD, COND_ALWAYS, UA_APPLIED, ST_OK};
      // pending operator dispatch, add and subtract inline
      6'd9:  word = '{ACT_NONE, COND_PEND_MUL, UA_MUL, ST_OK};
      6'd10: word = '{ACT_NONE, COND_PEND_DIV, UA_DIV, ST_OK};
      6'd11: word = '{ACT_NONE, COND_OPR_BIG, UA_OVF, ST_OK};
      6'd12: word = '{ACT_NONE, COND_SUM_OVF, UA_OVF, ST_OK};
      6'd13: word = '{ACT_ADDSUB, COND_ALWAYS, UA_APPLIED, ST_OK};
      // after apply: '=' reports, an operator becomes pending
      6'd14: word = '{ACT_NONE, COND_EQUAL, UA_OK, ST_OK};
      6'd15: word = '{ACT_SET_OP, COND_ALWAYS, UA_IDLE, ST_OK};
      // digit entry
      6'd16: word = '{ACT_NONE, COND_DIG_OVF, UA_OVF, ST_OK};
      6'd17: word = '{ACT_DIGIT, COND_ALWAYS, UA_IDLE, ST_OK};
      // discard until newline
      6'd18: word = '{ACT_NONE, COND_NOT_NEWLINE, UA_IDLE, ST_OK};
      6'd19: word = '{ACT_CLEAR, COND_ALWAYS, UA_IDLE, ST_OK};
      // shift-add multiply, one operand bit a step
      6'd20: word = '{ACT_MUL_INIT, COND_NEVER, UA_IDLE, ST_OK};
      6'd21: word = '{ACT_MUL_STEP, COND_MORE, UA_MUL_LP, ST_OK};
      6'd22: word = '{ACT_NONE, COND_MUL_OVF, UA_OVF, ST_OK};
      6'd23: word = '{ACT_MUL_STORE, COND_ALWAYS, UA_APPLIED, ST_OK};
      // restoring divide, one quotient bit a step
      6'd24: word = '{ACT_NONE, COND_OPND_ZERO, UA_DVZ, ST_OK};
      6'd25: word = '{ACT_DIV_INIT, COND_NEVER, UA_IDLE, ST_OK};
      6'd26: word = '{ACT_DIV_STEP, COND_MORE, UA_DIV_LP, ST_OK};
      6'd27: word = '{ACT_DIV_STORE, COND_ALWAYS, UA_APPLIED, ST_OK};
      // result reporting, each waits for a free output register
      6'd28: word = '{ACT_NONE, COND_OUT_BUSY, UA_SYN, ST_OK};
      6'd29: word = '{ACT_FINISH, COND_ALWAYS, UA_IDLE, ST_SYNTAX};
      6'd30: word = '{ACT_NONE, COND_OUT_BUSY, UA_OK, ST_OK};
      6'd31: word = '{ACT_FINISH, COND_ALWAYS, UA_IDLE, ST_OK};
      6'd32: word = '{ACT_NONE, COND_OUT_BUSY, UA_OVF, ST_OK};
      6'd33: word = '{ACT_FINISH, COND_ALWAYS, UA_IDLE, ST_OVERFLOW};
      6'd34: word = '{ACT_NONE, COND_OUT_BUSY, UA_DVZ, ST_OK};
      6'd35: word = '{ACT_FINISH, COND_ALWAYS, UA_IDLE, ST_DIVZERO};
      default: word = '{ACT_NONE, COND_ALWAYS, UA_IDLE, ST_OK};
    endcase
  end

endmodule

FILE: src/lrev_datapath.sv
// evaluator datapath: accumulator, operand, parse state and mul/div unit
module lrev_datapath #(
  parameter int FRAC_BITS    = 16,
  parameter int OPERAND_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lrev_pkg::ucode_t        ucode,
  input  logic                    take,
  input  logic [7:0]              character,
  output lrev_pkg::flags_t        flags,
  output logic [lrev_pkg::ACC_W-1:0] acc
);
  import lrev_pkg::*;

  localparam int OPW   = OPERAND_BITS + 4;
  localparam int IDX_W = $clog2(OPERAND_BITS);
  localparam int PW    = ACC_W + 2;
  localparam logic [ACC_W-1:0] SCALE_MAX = ACC_MAX >> FRAC_BITS;
  localparam logic [OPW-1:0]   OPND_MAX  = OPW'({(OPERAND_BITS-1){1'b1}});
  localparam logic [PW-1:0]    LIM_POS   = PW'(ACC_MAX);
  localparam logic [PW-1:0]    LIM_NEG   = PW'(ACC_MAX) + PW'(1);

  logic [OPERAND_BITS-1:0] operand;
  op_t                     pend;
  phase_t                  phase;
  logic                    have;

  logic [7:0]              ch;
  logic [ACC_W-1:0]        work;
  logic [ACC_W-1:0]        prod;
  logic [OPERAND_BITS-1:0] rem;
  logic                    neg;
  logic                    mul_ovf;
  logic [CNT_W-1:0]        cnt;

  logic [3:0]              digit;
  logic [OPW-1:0]          opnd_ext;
  logic [OPW-1:0]          opnd_next;
  logic [ACC_W-1:0]        op_scaled;
  logic [ACC_W:0]          sum;
  logic [ACC_W-1:0]        acc_mag;
  logic                    mul_bit;
  logic [PW-1:0]           p_next;
  logic [PW-1:0]           mul_lim;
  logic [OPERAND_BITS:0]   r_shift;
  logic [OPERAND_BITS:0]   r_diff;
  logic                    r_ge;
  op_t                     op_of_ch;

  // digit accumulation, times ten as shift and add
  assign digit     = 4'(ch - CH_ZERO);
  assign opnd_ext  = OPW'(operand);
  assign opnd_next = (phase == PH_FIRST) ? OPW'(digit)
                   : (opnd_ext << 3) + (opnd_ext << 1) + OPW'(digit);

  // scaled operand and add/subtract with range check
  assign op_scaled = ACC_W'(operand) << FRAC_BITS;
  assign sum = (pend == OP_SUB) ? {acc[ACC_W-1], acc} - {1'b0, op_scaled}
                                : {acc[ACC_W-1], acc} + {1'b0, op_scaled};

  assign acc_mag = acc[ACC_W-1] ? ACC_W'(0) - acc : acc;

  // multiply step, msb first over the operand bits
  assign mul_bit = operand[cnt[IDX_W-1:0]];
  assign mul_lim = neg ? LIM_NEG : LIM_POS;
  assign p_next  = (PW'(prod) << 1) + (mul_bit ? PW'(work) : PW'(0));

  // divide step, shift in the next dividend bit and try subtract
  assign r_shift = {rem, work[ACC_W-1]};
  assign r_diff  = r_shift - {1'b0, operand};
  assign r_ge    = r_shift >= {1'b0, operand};

  // operator code of the current character
  always_comb begin
    case (ch)
      CH_MINUS: op_of_ch = OP_SUB;
      CH_STAR:  op_of_ch = OP_MUL;
      CH_SLASH: op_of_ch = OP_DIV;
      default:  op_of_ch = OP_ADD;
    endcase
  end

  // status toward the sequencer
  always_comb begin
    flags.discard   = (phase != PH_FIRST) && (phase != PH_DIGITS);
    flags.newline   = ch == CH_LF;
    flags.space     = ch inside {CH_SPACE, [CH_TAB:CH_CR]};
    flags.digit     = ch inside {[CH_ZERO:CH_NINE]};
    flags.phase0    = phase == PH_FIRST;
    flags.not_opeq  = !(ch inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQUAL});
    flags.have      = have;
    flags.opr_big   = ACC_W'(operand) > SCALE_MAX;
    flags.pend_mul  = pend == OP_MUL;
    flags.pend_div  = pend == OP_DIV;
    flags.sum_ovf   = sum[ACC_W] ^ sum[ACC_W-1];
    flags.equal     = ch == CH_EQUAL;
    flags.dig_ovf   = opnd_next > OPND_MAX;
    flags.more      = cnt != '0;
    flags.mul_ovf   = mul_ovf;
    flags.opnd_zero = operand == '0;
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      operand <= '0;
      pend    <= OP_ADD;
      phase   <= PH_FIRST;
      have    <= 1'b0;
    end else begin
      case (ucode.act)
        ACT_LOAD: begin
          acc  <= op_scaled;
          have <= 1'b1;
        end
        ACT_ADDSUB: begin
          acc <= sum[ACC_W-1:0];
        end
        ACT_SET_OP: begin
          pend    <= op_of_ch;
          operand <= '0;
          phase   <= PH_FIRST;
        end
        ACT_DIGIT: begin
          operand <= opnd_next[OPERAND_BITS-1:0];
          phase   <= PH_DIGITS;
        end
        ACT_CLEAR: begin
          acc     <= '0;
          operand <= '0;
          pend    <= OP_ADD;
          have    <= 1'b0;
          phase   <= PH_FIRST;
        end
        ACT_FINISH: begin
          phase <= PH_DISCARD;
        end
        ACT_MUL_STORE: begin
          acc <= neg ? ACC_W'(0) - prod : prod;
        end
        ACT_DIV_STORE: begin
          acc <= neg ? ACC_W'(0) - work : work;
        end
        default: begin
        end
      endcase
    end
  end

  // character latch and mul/div working registers
  always_ff @(posedge clk) begin
    case (ucode.act)
      ACT_FETCH: begin
        if (take) begin
          ch <= character;
        end
      end
      ACT_MUL_INIT: begin
        work    <= acc_mag;
        neg     <= acc[ACC_W-1];
        prod    <= '0;
        mul_ovf <= 1'b0;
        cnt     <= CNT_W'(OPERAND_BITS - 1);
      end
      ACT_MUL_STEP: begin
        prod    <= p_next[ACC_W-1:0];
        mul_ovf <= mul_ovf | (p_next > mul_lim);
        cnt     <= cnt - CNT_W'(1);
      end
      ACT_DIV_INIT: begin
        work <= acc_mag;
        neg  <= acc[ACC_W-1];
        rem  <= '0;
        cnt  <= CNT_W'(ACC_W - 1);
      end
      ACT_DIV_STEP: begin
        rem  <= r_ge ? r_diff[OPERAND_BITS-1:0] : r_shift[OPERAND_BITS-1:0];
        work <= {work[ACC_W-2:0], r_ge};
        cnt  <= cnt - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: src/left_to_right_expression_evaluator.sv
// left-to-right expression evaluator: sequencer, output register, top level
//
//   channel   signals                     payload
//   input     in_valid / in_stall         character[7:0]
//   output    out_valid / out_stall       value[47:0] signed, status[1:0]
//
// An operator or '=' that applies a pending multiply runs a shift-add loop over
// the OPERAND_BITS operand bits; a pending divide runs the restoring divide loop
// over 48 bits, one quotient bit per cycle.
// Reset (rst, synchronous) returns the microcode counter to the fetch step,
// clears the expression state and empties the output register.
// in_stall is high whenever the sequencer is away from the fetch step; a
// result waits in the output register while out_stall is high, and the
// sequencer stops at the reporting step only if a second result is ready.
module left_to_right_expression_evaluator #(
  parameter int FRAC_BITS    = 16,
  parameter int OPERAND_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         character,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] value,
  output logic [1:0]         status
);
  import lrev_pkg::*;

  `include "left_to_right_expression_evaluator_defines.svh"

  upc_t             upc;
  upc_t             upc_next;
  ucode_t           ucode;
  flags_t           flags;
  logic [ACC_W-1:0] acc;
  logic             take;
  logic             out_busy;
  logic             jump;

  assign in_stall = upc != UA_IDLE;
  assign take     = in_valid && !in_stall;
  assign out_busy = out_valid && out_stall;

  lrev_ucode_rom u_rom (
    .addr (upc),
    .word (ucode)
  );

  lrev_datapath #(
    .FRAC_BITS    (FRAC_BITS),
    .OPERAND_BITS (OPERAND_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ucode     (ucode),
    .take      (take),
    .character (character),
    .flags     (flags),
    .acc       (acc)
  );

  // jump condition select
  always_comb begin
    case (ucode.cond)
      COND_NEVER:       jump = 1'b0;
      COND_ALWAYS:      jump = 1'b1;
      COND_NO_INPUT:    jump = !in_valid;
      COND_DISCARD:     jump = flags.discard;
      COND_SPACE:       jump = flags.space;
      COND_DIGIT:       jump = flags.digit;
      COND_PHASE0:      jump = flags.phase0;
      COND_NOT_OPEQ:    jump = flags.not_opeq;
      COND_HAVE:        jump = flags.have;
      COND_OPR_BIG:     jump = flags.opr_big;
      COND_PEND_MUL:    jump = flags.pend_mul;
      COND_PEND_DIV:    jump = flags.pend_div;
      COND_SUM_OVF:     jump = flags.sum_ovf;
      COND_EQUAL:       jump = flags.equal;
      COND_DIG_OVF:     jump = flags.dig_ovf;
      COND_NOT_NEWLINE: jump = !flags.newline;
      COND_OUT_BUSY:    jump = out_busy;
      COND_MORE:        jump = flags.more;
      COND_MUL_OVF:     jump = flags.mul_ovf;
      COND_OPND_ZERO:   jump = flags.opnd_zero;
      default:          jump = 1'b0;
    endcase
  end

  // step counter
  assign upc_next = jump ? ucode.target : upc_t'(upc + 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UA_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  // output register, loaded by the reporting step
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ucode.act == ACT_FINISH) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ucode.act == ACT_FINISH) begin
      value  <= (ucode.st == ST_OK) ? acc : '0;
      status <= ucode.st;
    end
  end

  `LREV_ASSERT(a_finish_when_free, clk, rst, (ucode.act == ACT_FINISH) |-> !out_busy, "result loaded over a waiting transaction")
  `LREV_ASSERT(a_busy_after_take, clk, rst, take |=> (upc != UA_IDLE), "sequencer did not leave fetch after a transaction")
  `LREV_ASSERT(a_error_zero_value, clk, rst, (out_valid && (status != ST_OK)) |-> (value == '0), "error result carries a nonzero value")
  `LREV_ASSERT_NR(a_out_empty_after_rst, clk, rst |=> !out_valid, "output valid right after reset")

endmodule

FILE: tb/left_to_right_expression_evaluator_test.sv
// self-checking testbench for the left-to-right expression evaluator
module left_to_right_expression_evaluator_test;
  import lrev_pkg::*;

  localparam int FRAC = 16;
  localparam longint TOTAL_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint TOTAL_MIN = -TOTAL_MAX - 1;
  localparam longint unsigned NUMBER_MAX = 64'h7FFF_FFFF;
  localparam byte unsigned CH_VT = 8'h0B;
  localparam byte unsigned CH_FF = 8'h0C;
  localparam byte unsigned BLANKS [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
  localparam byte unsigned OP_CHARS [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 100;

  typedef struct packed {
    logic signed [47:0] value;
    status_t            status;
  } answer_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         character = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [47:0] value;
  logic [1:0]         status;

  // evaluator state as the testbench sees it
  longint          running_total;
  longint unsigned typed_number;
  op_t             pending_op;
  phase_t          parse_phase;
  bit              have_total;

  answer_t      pending_answers[$];
  byte unsigned expr_chars[$];
  int           failures = 0;
  int           chars_sent = 0;
  int           answers_checked = 0;
  int           status_seen [4] = '{0, 0, 0, 0};
  int           quiet_cycles = 0;
  bit           no_idle = 1'b0;
  bit           hold_output = 1'b0;

  left_to_right_expression_evaluator i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .character (character),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // prediction

  function automatic void clear_expression();
    running_total = 0;
    typed_number  = 0;
    pending_op    = OP_ADD;
    have_total    = 1'b0;
  endfunction

  function automatic bit is_blank(byte unsigned c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  // one result per expression, then discard until newline
  function automatic void post_answer(status_t st);
    answer_t a;
    a.value  = (st == ST_OK) ? running_total[47:0] : 48'sd0;
    a.status = st;
    pending_answers.push_back(a);
    parse_phase = PH_DISCARD;
  endfunction

  // fold the typed number into the running total with the pending operator
  function automatic status_t apply_pending_op();
    longint          sum;
    bit              neg;
    longint unsigned mag;
    longint unsigned lim;
    longint unsigned prod;
    if (!have_total) begin
      if (typed_number > NUMBER_MAX) return ST_OVERFLOW;
      running_total = $signed(typed_number) <<< FRAC;
      have_total = 1'b1;
      return ST_OK;
    end
    case (pending_op)
      OP_ADD, OP_SUB: begin
        if (typed_number > NUMBER_MAX) return ST_OVERFLOW;
        if (pending_op == OP_ADD) sum = running_total + ($signed(typed_number) <<< FRAC);
        else sum = running_total - ($signed(typed_number) <<< FRAC);
        if (sum > TOTAL_MAX || sum < TOTAL_MIN) return ST_OVERFLOW;
        running_total = sum;
      end
      OP_MUL: begin
        neg = running_total < 0;
        mag = neg ? $unsigned(-running_total) : $unsigned(running_total);
        lim = neg ? $unsigned(TOTAL_MAX) + 1 : $unsigned(TOTAL_MAX);
        if (typed_number != 0 && mag > lim / typed_number) return ST_OVERFLOW;
        prod = mag * typed_number;
        running_total = neg ? -$signed(prod) : $signed(prod);
      end
      default: begin
        if (typed_number == 0) return ST_DIVZERO;
        running_total = running_total / $signed(typed_number);
      end
    endcase
    return ST_OK;
  endfunction

  function automatic void evaluate_character(byte unsigned c);
    longint unsigned next;
    status_t         st;
    // discarding: only a newline starts a fresh expression
    if (parse_phase != PH_FIRST && parse_phase != PH_DIGITS) begin
      if (c == CH_LF) begin
        clear_expression();
        parse_phase = PH_FIRST;
      end
      return;
    end
    if (is_blank(c)) return;
    // digits build the operand
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (parse_phase == PH_FIRST) next = c - CH_ZERO;
      else next = typed_number * 10 + (c - CH_ZERO);
      if (next > NUMBER_MAX) begin
        post_answer(ST_OVERFLOW);
        return;
      end
      typed_number = next;
      parse_phase = PH_DIGITS;
      return;
    end
    if (parse_phase == PH_FIRST) begin
      post_answer(ST_SYNTAX);
      return;
    end
    // operator or equals after a number
    if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
      st = apply_pending_op();
      if (st != ST_OK) begin
        post_answer(st);
        return;
      end
      case (c)
        CH_PLUS:  pending_op = OP_ADD;
        CH_MINUS: pending_op = OP_SUB;
        CH_STAR:  pending_op = OP_MUL;
        default:  pending_op = OP_DIV;
      endcase
      typed_number = 0;
      parse_phase = PH_FIRST;
    end else if (c == CH_EQUAL) begin
      post_answer(apply_pending_op());
    end else begin
      post_answer(ST_SYNTAX);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checking and prediction at each accepted transaction

  always @(posedge clk) begin : track
    answer_t want;
    if (rst) begin
      clear_expression();
      parse_phase = PH_FIRST;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_answers.size() == 0) begin
          $error("result with none expected: value %0d status %0d", value, status);
          failures++;
        end else begin
          want = pending_answers.pop_front();
          if (value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, value);
            failures++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            failures++;
          end
          answers_checked++;
          status_seen[want.status]++;
        end
      end
      if (in_valid && !in_stall) evaluate_character(character);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // idling of both sides

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // receiver: random stall bursts, or one long hold when asked
  always begin : receiver
    int pause;
    @(posedge clk);
    if (hold_output) begin
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_output = 1'b0;
      out_stall <= 1'b0;
    end else begin
      pause = pick_gap();
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // sender

  // valid stays high between back-to-back transactions
  task automatic send_char(input byte unsigned c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    character <= c;
    do @(posedge clk); while (in_stall);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_expression();
    foreach (expr_chars[i]) send_char(expr_chars[i]);
  endtask

  function automatic void add_number();
    int r;
    int digits;
    r = $urandom_range(0, 99);
    if (r < 60) digits = $urandom_range(1, 2);
    else if (r < 90) digits = $urandom_range(3, 5);
    else digits = $urandom_range(6, 10);
    for (int i = 0; i < digits; i++) begin
      if ($urandom_range(0, 19) == 0) expr_chars.push_back(BLANKS[$urandom_range(0, 5)]);
      expr_chars.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    end
  endfunction

  // well-formed expression, optionally with one stray character inserted
  function automatic void build_expression(bit broken);
    expr_chars.delete();
    add_number();
    repeat ($urandom_range(0, 5)) begin
      if ($urandom_range(0, 3) == 0) expr_chars.push_back(CH_SPACE);
      expr_chars.push_back(OP_CHARS[$urandom_range(0, 3)]);
      if ($urandom_range(0, 3) == 0) expr_chars.push_back(BLANKS[$urandom_range(0, 5)]);
      add_number();
    end
    expr_chars.push_back(CH_EQUAL);
    if (broken)
      expr_chars.insert($urandom_range(0, expr_chars.size() - 1), 8'($urandom_range(0, 255)));
    // trailing characters that the block discards
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) expr_chars.push_back(8'($urandom_range(0, 255)));
    expr_chars.push_back(CH_LF);
  endfunction

  // ---------------------------------------------------------------------------
  // tests

  task automatic test_operations();
    send_text("7=\n");
    send_text("12+3*4=\n");
    send_text("9-20/3=\n");
    send_text("0-3*5=\n");
    send_text("0-1/2=\n");
    send_text("100/7*7=\n");
  endtask

  task automatic test_whitespace();
    send_text("1 2\t3\r\v\f=\n");
    send_text(" \n 4 + 5 =\n");
    send_text("8-\n9=\n");
  endtask

  task automatic test_syntax_errors();
    send_text("=\n");
    send_text("+1=\n");
    send_text("4x\n");
    send_text("4+*2=\n");
    send_text("3=junk=\n");
  endtask

  task automatic test_arithmetic_errors();
    send_text("5/0=\n");
    send_text("2147483647=\n");
    send_text("2147483648=\n");
    send_text("2147483647+2147483647=\n");
    send_text("0-2147483647-2147483647=\n");
    send_text("2147483647*65535=\n");
    send_text("0-32768*65536=\n");
    send_text("32768*65536=\n");
  endtask

  task automatic test_extreme_characters();
    send_char(8'h00);
    send_char(CH_LF);
    send_char(8'hFF);
    send_char(CH_LF);
    send_char(8'h31);
    send_char(8'h7F);
    send_char(CH_LF);
  endtask

  task automatic test_random_expressions(input int target);
    while (chars_sent < target) begin
      build_expression($urandom_range(0, 4) == 0);
      send_expression();
    end
  endtask

  // no idling on either side
  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (8) begin
      build_expression(1'b0);
      send_expression();
    end
    no_idle = 1'b0;
  endtask

  // receiver holds off while the sender keeps going until the block fills up
  task automatic test_output_hold();
    hold_output = 1'b1;
    repeat (10) begin
      build_expression(1'b0);
      send_expression();
    end
  endtask

  // random bytes of the whole range, then a close
  task automatic test_random_noise();
    repeat (8) begin
      repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
      send_char(CH_EQUAL);
      send_char(CH_LF);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_operations();
    test_whitespace();
    test_syntax_errors();
    test_arithmetic_errors();
    test_extreme_characters();
    test_random_expressions(300);
    test_back_to_back();
    test_output_hold();
    test_random_noise();
    test_random_expressions(650);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    failures += pending_answers.size();
    $display("sent %0d characters, checked %0d results", chars_sent, answers_checked);
    $display("status mix: ok %0d, syntax %0d, divide by zero %0d, overflow %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/lrev_pkg.sv
src/lrev_ucode_rom.sv
src/lrev_datapath.sv
src/left_to_right_expression_evaluator.sv
tb/left_to_right_expression_evaluator_test.sv
